// File: src/ilide_pkg.sv
// Shared types, codes and sizes for the indexed list insert/delete engine.
package ilide_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int OPC_W       = 4;
   localparam int STAT_W      = 3;
   localparam int FIDX_W      = 7;
   localparam int POS_W       = 6;
   localparam int REQ_BITS    = OPC_W + POS_W + VALUE_WIDTH;
   localparam int RSP_BITS    = STAT_W + VALUE_WIDTH + FIDX_W + CNT_W;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OPC_W-1:0] {
      OP_INS_BEFORE = 4'd0,
      OP_INS_AFTER  = 4'd1,
      OP_PUSH_BACK  = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_POP_BACK   = 4'd4,
      OP_DELETE_AT  = 4'd5,
      OP_READ_AT    = 4'd6,
      OP_FIND       = 4'd7,
      OP_CLEAR      = 4'd8
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_BADPOS = 3'd3,
      ST_NULL   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_UP_RD,
      S_UP_WR,
      S_PUT,
      S_TAKE_RD,
      S_TAKE,
      S_DN_RD,
      S_DN_WR,
      S_FIND_RD,
      S_FIND_CMP,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_COUNT,
      PTR_AT,
      PTR_CNT_M1,
      PTR_DEC,
      PTR_INC
   } ptr_cmd_type;

   typedef enum logic [1:0] {
      RD_PTR,
      RD_PTR_M1,
      RD_PTR_P1
   } rd_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_cmd_type;

   typedef struct packed {
      logic        load_req;
      ptr_cmd_type ptr_cmd;
      rd_sel_type  rd_sel;
      logic        wr_en;
      logic        wr_put;
      cnt_cmd_type cnt_cmd;
      logic        init_result;
      logic        take_value;
      logic        set_fidx;
      logic        set_miss;
      logic        rsp_load;
   } ctl_type;

   typedef struct packed {
      op_type op;
      logic   chk_ok;
      logic   cnt_eq_at;
      logic   ptr_m1_eq_at;
      logic   ptr_p1_lt_cnt;
      logic   ptr_p2_lt_cnt;
      logic   ptr_zero;
      logic   match;
      logic   out_free;
   } dp_status_type;

endpackage

// File: src/ilide_ctrl.sv
// Controller state machine: sequences checks, memory sweeps and the result beat.
module ilide_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ilide_pkg::dp_status_type dp_st,
   output ilide_pkg::ctl_type     ctl
);
   import ilide_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!dp_st.chk_ok) begin
               state_in = S_DONE;
            end else begin
               case (dp_st.op)
                  OP_INS_BEFORE, OP_INS_AFTER, OP_PUSH_BACK: begin
                     state_in = dp_st.cnt_eq_at ? S_PUT : S_UP_RD;
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT, OP_READ_AT: begin
                     state_in = S_TAKE_RD;
                  end
                  OP_FIND: state_in = S_FIND_RD;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_UP_RD:   state_in = S_UP_WR;
         S_UP_WR:   state_in = dp_st.ptr_m1_eq_at ? S_PUT : S_UP_RD;
         S_PUT:     state_in = S_DONE;
         S_TAKE_RD: state_in = S_TAKE;
         S_TAKE: begin
            if (dp_st.op == OP_READ_AT) state_in = S_DONE;
            else if (dp_st.ptr_p1_lt_cnt) state_in = S_DN_RD;
            else state_in = S_DONE;
         end
         S_DN_RD:   state_in = S_DN_WR;
         S_DN_WR:   state_in = dp_st.ptr_p2_lt_cnt ? S_DN_RD : S_DONE;
         S_FIND_RD: state_in = S_FIND_CMP;
         S_FIND_CMP: begin
            if (dp_st.match || dp_st.ptr_zero) state_in = S_DONE;
            else state_in = S_FIND_RD;
         end
         S_DONE: begin
            if (dp_st.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      ctl         = '0;
      ctl.ptr_cmd = PTR_HOLD;
      ctl.rd_sel  = RD_PTR;
      ctl.cnt_cmd = CNT_HOLD;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // No beat is taken while reset is held.
            req_tready   = !reset;
            ctl.load_req = req_tvalid && !reset;
         end
         S_CHECK: begin
            ctl.init_result = 1'b1;
            if (dp_st.chk_ok) begin
               case (dp_st.op)
                  OP_INS_BEFORE, OP_INS_AFTER, OP_PUSH_BACK: ctl.ptr_cmd = PTR_COUNT;
                  OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT, OP_READ_AT: begin
                     ctl.ptr_cmd = PTR_AT;
                  end
                  OP_FIND:  ctl.ptr_cmd = PTR_CNT_M1;
                  OP_CLEAR: ctl.cnt_cmd = CNT_CLEAR;
                  default:  ctl.ptr_cmd = PTR_HOLD;
               endcase
            end
         end
         S_UP_RD: ctl.rd_sel = RD_PTR_M1;
         S_UP_WR: begin
            ctl.wr_en   = 1'b1;
            ctl.ptr_cmd = PTR_DEC;
         end
         S_PUT: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_put  = 1'b1;
            ctl.cnt_cmd = CNT_INC;
         end
         S_TAKE_RD: ctl.rd_sel = RD_PTR;
         S_TAKE: begin
            ctl.take_value = 1'b1;
            if (dp_st.op != OP_READ_AT && !dp_st.ptr_p1_lt_cnt) ctl.cnt_cmd = CNT_DEC;
         end
         S_DN_RD: ctl.rd_sel = RD_PTR_P1;
         S_DN_WR: begin
            ctl.wr_en   = 1'b1;
            ctl.ptr_cmd = PTR_INC;
            if (!dp_st.ptr_p2_lt_cnt) ctl.cnt_cmd = CNT_DEC;
         end
         S_FIND_RD: ctl.rd_sel = RD_PTR;
         S_FIND_CMP: begin
            if (dp_st.match) ctl.set_fidx = 1'b1;
            else if (dp_st.ptr_zero) ctl.set_miss = 1'b1;
            else ctl.ptr_cmd = PTR_DEC;
         end
         S_DONE: ctl.rsp_load = dp_st.out_free;
         default: ctl.load_req = 1'b0;
      endcase
   end

   // The list store is only written while a request is being worked on.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ctl.wr_en)
      else $error("list store written while idle");

   // A result is loaded only from the final state.
   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (state_ff == S_DONE))
      else $error("result loaded outside the final state");

   // A request beat is only offered to be taken while idle.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == S_IDLE))
      else $error("request ready outside the idle state");

endmodule

// File: src/ilide_dpath.sv
// Datapath: list store, count, sweep pointer, checks and the result register.
module ilide_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ilide_pkg::REQ_W-1:0] req_tdata,
   input  ilide_pkg::ctl_type        ctl,
   output ilide_pkg::dp_status_type  dp_st,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ilide_pkg::RSP_W-1:0] rsp_tdata
);
   import ilide_pkg::*;

   logic [VALUE_WIDTH-1:0] entries_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rdata_ff;

   op_type                 op_ff, op_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   status_type             res_status_ff, res_status_in;
   logic [VALUE_WIDTH-1:0] rv_ff, rv_in;
   logic [FIDX_W-1:0]      fidx_ff, fidx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   status_type             chk_status;
   logic [ADDR_W-1:0]      at_c;
   logic [CNT_W-1:0]       count_m1;
   logic [CNT_W-1:0]       pos_ext;
   logic [CNT_W-1:0]       ptr_ext;
   logic                   val_zero;
   logic                   full;
   logic                   empty;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   assign count_m1 = count_ff - CNT_W'(1);
   assign pos_ext  = CNT_W'(pos_ff);
   assign ptr_ext  = CNT_W'(ptr_ff);
   assign val_zero = (val_ff == '0);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);

   // Checks in order: null value, full, empty, bad position.
   always_comb begin
      chk_status = ST_OK;
      at_c       = pos_ff[ADDR_W-1:0];
      case (op_ff)
         OP_INS_BEFORE: begin
            if (val_zero) chk_status = ST_NULL;
            else if (full) chk_status = ST_FULL;
            else if (pos_ext > count_ff) chk_status = ST_BADPOS;
         end
         OP_INS_AFTER: begin
            at_c = pos_ff[ADDR_W-1:0] + ADDR_W'(1);
            if (val_zero) chk_status = ST_NULL;
            else if (full) chk_status = ST_FULL;
            else if (empty) chk_status = ST_EMPTY;
            else if (pos_ext >= count_ff) chk_status = ST_BADPOS;
         end
         OP_PUSH_BACK: begin
            at_c = count_ff[ADDR_W-1:0];
            if (val_zero) chk_status = ST_NULL;
            else if (full) chk_status = ST_FULL;
         end
         OP_POP_FRONT: begin
            at_c = '0;
            if (empty) chk_status = ST_EMPTY;
         end
         OP_POP_BACK: begin
            at_c = count_m1[ADDR_W-1:0];
            if (empty) chk_status = ST_EMPTY;
         end
         OP_DELETE_AT, OP_READ_AT: begin
            if (empty) chk_status = ST_EMPTY;
            else if (pos_ext >= count_ff) chk_status = ST_BADPOS;
         end
         OP_FIND: begin
            if (val_zero || empty) chk_status = ST_NULL;
         end
         default: chk_status = ST_OK;
      endcase
   end

   always_comb begin
      dp_st.op            = op_ff;
      dp_st.chk_ok        = (chk_status == ST_OK);
      dp_st.cnt_eq_at     = (count_ff == CNT_W'(at_c));
      dp_st.ptr_m1_eq_at  = ((ptr_ff - ADDR_W'(1)) == at_c);
      dp_st.ptr_p1_lt_cnt = ((ptr_ext + CNT_W'(1)) < count_ff);
      dp_st.ptr_p2_lt_cnt = ((ptr_ext + CNT_W'(2)) < count_ff);
      dp_st.ptr_zero      = (ptr_ff == '0);
      dp_st.match         = (rdata_ff == val_ff);
      dp_st.out_free      = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      case (ctl.rd_sel)
         RD_PTR_M1: rd_addr = ptr_ff - ADDR_W'(1);
         RD_PTR_P1: rd_addr = ptr_ff + ADDR_W'(1);
         default:   rd_addr = ptr_ff;
      endcase
      wr_addr = ctl.wr_put ? at_c : ptr_ff;
      wr_data = ctl.wr_put ? val_ff : rdata_ff;
   end

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) entries_ff[wr_addr] <= wr_data;
      rdata_ff <= entries_ff[rd_addr];
   end

   always_comb begin
      op_in  = op_ff;
      pos_in = pos_ff;
      val_in = val_ff;
      if (ctl.load_req) begin
         op_in  = op_type'(req_tdata[OPC_W-1:0]);
         pos_in = req_tdata[OPC_W +: POS_W];
         val_in = req_tdata[OPC_W+POS_W +: VALUE_WIDTH];
      end

      case (ctl.cnt_cmd)
         CNT_INC:   count_in = count_ff + CNT_W'(1);
         CNT_DEC:   count_in = count_m1;
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase

      case (ctl.ptr_cmd)
         PTR_COUNT:  ptr_in = count_ff[ADDR_W-1:0];
         PTR_AT:     ptr_in = at_c;
         PTR_CNT_M1: ptr_in = count_m1[ADDR_W-1:0];
         PTR_DEC:    ptr_in = ptr_ff - ADDR_W'(1);
         PTR_INC:    ptr_in = ptr_ff + ADDR_W'(1);
         default:    ptr_in = ptr_ff;
      endcase

      res_status_in = res_status_ff;
      rv_in         = rv_ff;
      fidx_in       = fidx_ff;
      if (ctl.init_result) begin
         res_status_in = chk_status;
         rv_in         = '0;
         fidx_in       = (op_ff == OP_FIND && chk_status != ST_OK) ? '1 : '0;
      end
      if (ctl.take_value) rv_in = rdata_ff;
      if (ctl.set_fidx) fidx_in = FIDX_W'(ptr_ff);
      if (ctl.set_miss) begin
         res_status_in = ST_NULL;
         fidx_in       = '1;
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({count_ff, fidx_ff, rv_ff, res_status_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      rv_ff         <= rv_in;
      fidx_ff       <= fidx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // The count moves by one per request, or drops to zero on clear.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CNT_W'(1)) ||
                        (count_ff == $past(count_ff) - CNT_W'(1)) ||
                        (count_ff == '0))
      else $error("entry count jumped");

   // Shifts never write past the slot just above the last held entry.
   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> (CNT_W'(wr_addr) <= count_ff))
      else $error("list store written beyond the list");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[STAT_W-1:0] <= ST_NULL))
      else $error("result beat carries an undefined status");

endmodule

// File: src/indexed_list_insert_delete_engine_top.sv
// A request beat is checked and ends in a registered result beat; a failed check, a clear or an
// unknown opcode go straight to it. An insert shifts entries up, a pop or delete moves later
// entries down, a find scans from the back; each step is a read state, then a write or compare.
// Throughput: one request at a time; the next request beat is taken the cycle after the result
// is registered, even while that result still waits to be taken.
// Reset clears the count, the controller and the result valid; list contents are not cleared.
module indexed_list_insert_delete_engine_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // opcode [3:0], position [9:4], entry_value [41:10], zero fill above
   input  logic [ilide_pkg::REQ_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status [2:0], read_value [34:3], found_index [41:35], entry_count [48:42], zero fill above
   output logic [ilide_pkg::RSP_W-1:0] rsp_tdata
);
   import ilide_pkg::*;

   ctl_type       ctl;
   dp_status_type dp_st;

   ilide_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_st      (dp_st),
      .ctl        (ctl)
   );

   ilide_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .ctl        (ctl),
      .dp_st      (dp_st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
